// ===== rtl/gam_pkg.sv =====
// gam_pkg: shared constants, register indexes and lane result type for the
// gyro air-mouse motion block. Used by every module under rtl/.
package gam_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // port and field widths
  localparam int CFG_W     = 22;
  localparam int IDX_W     = 3;
  localparam int RATE_W    = 22;
  localparam int DZ_W      = 21;
  localparam int GAIN_W    = 16;
  localparam int BETA_W    = 16;
  localparam int TIME_W    = 16;
  localparam int ELAPSED_W = 20;
  localparam int BTN_W     = 2;
  localparam int MOVE_W    = 8;

  // datapath widths of the rate scaling
  localparam int DIFF_W      = RATE_W + 1;
  localparam int MAG_W       = RATE_W;
  localparam int P1_W        = MAG_W + GAIN_W;
  localparam int P_W         = P1_W + TIME_W;
  // 256e9 = 2^17 * 1953125
  localparam int SCALE_SHIFT = 17;
  localparam int DIV_W       = 21;
  localparam logic [DIV_W-1:0] DIV_CONST = 21'd1953125;
  // divisor is at least 2^20, so the top 20 dividend bits give no quotient bit
  localparam int DIV_FLOOR   = 20;
  localparam int DIV_STEP    = 4;

  localparam logic [ELAPSED_W-1:0] TIME_MIN = 20'd1000;
  localparam logic [ELAPSED_W-1:0] TIME_MAX = 20'd50000;
  localparam logic signed [MOVE_W-1:0] MOVE_MAX = 8'sd127;

  // register indexes
  localparam logic [IDX_W-1:0] REG_BIAS_X     = 3'd0;
  localparam logic [IDX_W-1:0] REG_BIAS_Y     = 3'd1;
  localparam logic [IDX_W-1:0] REG_DEADZONE   = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_HORIZ = 3'd3;
  localparam logic [IDX_W-1:0] REG_GAIN_VERT  = 3'd4;
  localparam logic [IDX_W-1:0] REG_SMOOTHING  = 3'd5;
  localparam logic [IDX_W-1:0] REG_ENABLE     = 3'd6;

  // register reset values
  localparam logic [DZ_W-1:0]   DEADZONE_RST  = 21'd2000;
  localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd2560;
  localparam logic [BETA_W-1:0] SMOOTHING_RST = 16'd22938;

  typedef struct packed {
    logic              done;
    logic [MOVE_W-1:0] move;
  } gam_lane_res_t;

endpackage

// ===== rtl/gam_div.sv =====
// gam_div: multi-cycle restoring divider by the fixed scale constant,
// DIV_STEP quotient bits per cycle. Depends on gam_pkg.
module gam_div #(
  parameter int FRAC_BITS = gam_pkg::FRAC_BITS_DEF
) (
  input  logic                                                      clk,
  input  logic                                                      rst_n,
  input  logic                                                      start_i,
  input  logic [gam_pkg::P_W+FRAC_BITS-gam_pkg::SCALE_SHIFT-1:0]    num_i,
  output logic                                                      done_o,
  output logic [gam_pkg::P_W+FRAC_BITS-gam_pkg::SCALE_SHIFT-gam_pkg::DIV_FLOOR-1:0] quo_o
);

  localparam int N_W   = gam_pkg::P_W + FRAC_BITS - gam_pkg::SCALE_SHIFT;
  localparam int Q_W   = N_W - gam_pkg::DIV_FLOOR;
  localparam int STEP  = gam_pkg::DIV_STEP;
  localparam int ITER  = (Q_W + STEP - 1) / STEP;
  localparam int Q_PAD = ITER * STEP;
  localparam int TOP_W = N_W - Q_PAD;
  localparam int D_W   = gam_pkg::DIV_W;
  localparam int CNT_W = $clog2(ITER + 1);

  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [Q_PAD-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  always_comb begin
    logic [D_W:0] trial;
    logic [D_W:0] sub;
    rem_nxt = rem_r;
    sh_nxt  = sh_r;
    for (int k = 0; k < STEP; k++) begin
      trial = {rem_nxt, sh_nxt[Q_PAD-1]};
      sub   = trial - {1'b0, gam_pkg::DIV_CONST};
      if (trial >= {1'b0, gam_pkg::DIV_CONST}) begin
        rem_nxt = sub[D_W-1:0];
        sh_nxt  = {sh_nxt[Q_PAD-2:0], 1'b1};
      end else begin
        rem_nxt = trial[D_W-1:0];
        sh_nxt  = {sh_nxt[Q_PAD-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        cnt_r <= CNT_W'(ITER);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= {{(D_W-TOP_W){1'b0}}, num_i[N_W-1:Q_PAD]};
      sh_r  <= num_i[Q_PAD-1:0];
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
    end
  end

  assign done_o = done_r;
  assign quo_o  = sh_r[Q_W-1:0];

endmodule

// ===== rtl/gam_lane.sv =====
// gam_lane: one pointer axis: bias, deadzone, gain and time scaling, smoothing
// filter and fractional residue. Depends on gam_pkg and gam_div.
module gam_lane #(
  parameter int FRAC_BITS = gam_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start_i,
  input  logic                                clear_i,
  input  logic                                negate_i,
  input  logic signed [gam_pkg::RATE_W-1:0]   rate_i,
  input  logic signed [gam_pkg::RATE_W-1:0]   bias_i,
  input  logic [gam_pkg::DZ_W-1:0]            dz_i,
  input  logic [gam_pkg::GAIN_W-1:0]          gain_i,
  input  logic [gam_pkg::BETA_W-1:0]          beta_i,
  input  logic [gam_pkg::TIME_W-1:0]          time_i,
  output gam_pkg::gam_lane_res_t              res_o
);

  localparam int F     = FRAC_BITS;
  localparam int BW    = gam_pkg::BETA_W;
  localparam int MW    = gam_pkg::MOVE_W;
  localparam int DW    = gam_pkg::DIFF_W;
  localparam int N_W   = gam_pkg::P_W + F - gam_pkg::SCALE_SHIFT;
  localparam int Q_W   = N_W - gam_pkg::DIV_FLOOR;
  localparam int F_W   = Q_W + 1;
  localparam int DF_W  = F_W + 1;
  localparam int LO_W  = DF_W / 2;
  localparam int HI_W  = DF_W - LO_W;
  localparam int PH_W  = HI_W + BW + 1;
  localparam int PL_W  = LO_W + BW;
  localparam int S_W   = F_W + BW + 2;
  localparam int R_W   = 24 + F;
  localparam int IP_W  = R_W - F;

  localparam logic signed [R_W:0] LIM_P = {2'b00, {(R_W-1){1'b1}}};
  localparam logic signed [R_W:0] LIM_N = -LIM_P;
  localparam logic signed [IP_W-1:0] IP_MAX = IP_W'(gam_pkg::MOVE_MAX);
  localparam logic signed [IP_W-1:0] IP_MIN = -IP_MAX;

  localparam logic [3:0] L_IDLE  = 4'd0;
  localparam logic [3:0] L_MAG   = 4'd1;
  localparam logic [3:0] L_MUL1  = 4'd2;
  localparam logic [3:0] L_MUL2  = 4'd3;
  localparam logic [3:0] L_DIVGO = 4'd4;
  localparam logic [3:0] L_DIVW  = 4'd5;
  localparam logic [3:0] L_SGN   = 4'd6;
  localparam logic [3:0] L_FDIF  = 4'd7;
  localparam logic [3:0] L_FMUL  = 4'd8;
  localparam logic [3:0] L_FSUM  = 4'd9;
  localparam logic [3:0] L_FILT  = 4'd10;
  localparam logic [3:0] L_RES   = 4'd11;
  localparam logic [3:0] L_MOVE  = 4'd12;
  localparam logic [3:0] L_UPD   = 4'd13;

  logic [3:0] st_r, st_nxt;
  logic       done_r;

  logic [DW-1:0]                diff_r;
  logic [gam_pkg::TIME_W-1:0]   time_r;
  logic [gam_pkg::MAG_W-1:0]    mag_r, mag_nxt;
  logic                         neg_r;
  logic [gam_pkg::P1_W-1:0]     p1_r;
  logic [gam_pkg::P_W-1:0]      p_r;
  logic [gam_pkg::P_W+F-1:0]    pw;
  logic                         div_done;
  logic [Q_W-1:0]               quo;
  logic [F_W-1:0]               d_r, q_ext;
  logic [DF_W-1:0]              fd_r;
  logic signed [PH_W-1:0]       ph_r;
  logic [PL_W-1:0]              pl_r;
  logic [S_W-1:0]               sum_r, sum_nxt, adj_v;
  logic [F_W-1:0]               filt_r, filt_nxt;
  logic [R_W:0]                 rsum_v;
  logic [R_W-1:0]               rsat_r, rsat_nxt, adj2_v, res_r, res_nxt;
  logic signed [IP_W-1:0]       ip_v;
  logic [MW-1:0]                mv_r, mv_nxt;
  logic [DW-1:0]                abs_v;

  // rate * gain * time scaled by 2^F / 256e9; the power-of-two part is a shift
  assign pw = {p_r, {F{1'b0}}};

  gam_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (st_r == L_DIVGO),
    .num_i   (pw[gam_pkg::P_W+F-1:gam_pkg::SCALE_SHIFT]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      L_IDLE:  if (start_i) st_nxt = L_MAG;
      L_MAG:   st_nxt = L_MUL1;
      L_MUL1:  st_nxt = L_MUL2;
      L_MUL2:  st_nxt = L_DIVGO;
      L_DIVGO: st_nxt = L_DIVW;
      L_DIVW:  if (div_done) st_nxt = L_SGN;
      L_SGN:   st_nxt = L_FDIF;
      L_FDIF:  st_nxt = L_FMUL;
      L_FMUL:  st_nxt = L_FSUM;
      L_FSUM:  st_nxt = L_FILT;
      L_FILT:  st_nxt = L_RES;
      L_RES:   st_nxt = L_MOVE;
      L_MOVE:  st_nxt = L_UPD;
      L_UPD:   st_nxt = L_IDLE;
      default: st_nxt = L_IDLE;
    endcase
  end

  always_comb begin
    abs_v   = diff_r[DW-1] ? (~diff_r + 1'b1) : diff_r;
    mag_nxt = (abs_v[gam_pkg::MAG_W-1:0] < {1'b0, dz_i}) ? '0 : abs_v[gam_pkg::MAG_W-1:0];
    q_ext   = {1'b0, quo};

    // beta*old + (1-beta)*d  ==  d*2^16 + beta*(old - d)
    sum_nxt = {{2{d_r[F_W-1]}}, d_r, {BW{1'b0}}}
            + {ph_r, {LO_W{1'b0}}}
            + {{(S_W-PL_W){1'b0}}, pl_r};
    // truncate toward zero
    adj_v    = sum_r + (sum_r[S_W-1] ? {{(S_W-BW){1'b0}}, {BW{1'b1}}} : '0);
    filt_nxt = adj_v[F_W+BW-1:BW];

    rsum_v = {res_r[R_W-1], res_r} + {{(R_W+1-F_W){filt_r[F_W-1]}}, filt_r};
    if ($signed(rsum_v) > LIM_P) begin
      rsat_nxt = LIM_P[R_W-1:0];
    end else if ($signed(rsum_v) < LIM_N) begin
      rsat_nxt = LIM_N[R_W-1:0];
    end else begin
      rsat_nxt = rsum_v[R_W-1:0];
    end

    adj2_v = rsat_r + (rsat_r[R_W-1] ? {{(R_W-F){1'b0}}, {F{1'b1}}} : '0);
    ip_v   = adj2_v[R_W-1:F];
    if (ip_v > IP_MAX) begin
      mv_nxt = IP_MAX[MW-1:0];
    end else if (ip_v < IP_MIN) begin
      mv_nxt = IP_MIN[MW-1:0];
    end else begin
      mv_nxt = ip_v[MW-1:0];
    end

    res_nxt = rsat_r - {{(R_W-MW-F){mv_r[MW-1]}}, mv_r, {F{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
      filt_r <= '0;
      res_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == L_UPD);
      if (clear_i) begin
        filt_r <= '0;
        res_r  <= '0;
      end else begin
        if (st_r == L_FILT) filt_r <= filt_nxt;
        if (st_r == L_UPD)  res_r  <= res_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      L_IDLE: begin
        if (start_i) begin
          diff_r <= {rate_i[gam_pkg::RATE_W-1], rate_i} - {bias_i[gam_pkg::RATE_W-1], bias_i};
          time_r <= time_i;
        end
      end
      L_MAG: begin
        mag_r <= mag_nxt;
        neg_r <= diff_r[DW-1] ^ negate_i;
      end
      L_MUL1:  p1_r  <= mag_r * gain_i;
      L_MUL2:  p_r   <= p1_r * time_r;
      L_SGN:   d_r   <= neg_r ? (~q_ext + 1'b1) : q_ext;
      L_FDIF:  fd_r  <= {filt_r[F_W-1], filt_r} - {d_r[F_W-1], d_r};
      L_FMUL: begin
        ph_r <= $signed({1'b0, beta_i}) * $signed(fd_r[DF_W-1:LO_W]);
        pl_r <= beta_i * fd_r[LO_W-1:0];
      end
      L_FSUM:  sum_r  <= sum_nxt;
      L_RES:   rsat_r <= rsat_nxt;
      L_MOVE:  mv_r   <= mv_nxt;
      default: ;
    endcase
  end

  assign res_o.done = done_r;
  assign res_o.move = mv_r;

endmodule

// ===== rtl/gam_merge.sv =====
// gam_merge: combines the two lane moves, drops all-zero moves and holds the
// result request in an output register. Depends on gam_pkg.
module gam_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gam_pkg::gam_lane_res_t            lx_i,
  input  gam_pkg::gam_lane_res_t            ly_i,
  input  logic [gam_pkg::BTN_W-1:0]         btn_i,
  output logic                              retire_o,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [gam_pkg::MOVE_W-1:0] out_move_x,
  output logic signed [gam_pkg::MOVE_W-1:0] out_move_y,
  output logic [gam_pkg::BTN_W-1:0]         out_button_state
);

  logic                        out_valid_r, out_valid_nxt;
  logic                        pend_r, pend_nxt;
  logic                        nz, free, load;
  logic [gam_pkg::MOVE_W-1:0]  mx_r, my_r;
  logic [gam_pkg::BTN_W-1:0]   btn_r;

  // both lanes run in lockstep, so the x lane's done marks both
  always_comb begin
    nz   = (lx_i.move != '0) || (ly_i.move != '0);
    free = !out_valid_r || out_ready;
    load = (lx_i.done && nz && free) || (pend_r && free);
    retire_o = (lx_i.done && (!nz || free)) || (pend_r && free);
    pend_nxt = pend_r;
    if (lx_i.done && nz && !free) begin
      pend_nxt = 1'b1;
    end else if (pend_r && free) begin
      pend_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mx_r  <= lx_i.move;
      my_r  <= ly_i.move;
      btn_r <= btn_i;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_move_x       = mx_r;
  assign out_move_y       = my_r;
  assign out_button_state = btn_r;

endmodule

// ===== rtl/gyro_air_mouse_motion_top.sv =====
// gyro_air_mouse_motion_top: gyro air-mouse pointer motion, one lane per axis.
// A nonzero result is offered once the lane states and the scale divider have run
// on the accepted input request. A new sample is taken only after the last retires;
// the output register lets the next sample start while a result waits.
// Reset (rst_n low, synchronous) loads register defaults and clears filters.
module gyro_air_mouse_motion_top #(
  parameter int FRAC_BITS = gam_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [gam_pkg::RATE_W-1:0]    in_rate_raw_x,
  input  logic signed [gam_pkg::RATE_W-1:0]    in_rate_raw_y,
  input  logic [gam_pkg::ELAPSED_W-1:0]        in_elapsed_us,
  input  logic [gam_pkg::BTN_W-1:0]            in_buttons,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [gam_pkg::MOVE_W-1:0]    out_move_x,
  output logic signed [gam_pkg::MOVE_W-1:0]    out_move_y,
  output logic [gam_pkg::BTN_W-1:0]            out_button_state,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gam_pkg::IDX_W-1:0]            cfg_index,
  input  logic [gam_pkg::CFG_W-1:0]            cfg_data
);

  logic signed [gam_pkg::RATE_W-1:0] bias_x_r, bias_y_r;
  logic [gam_pkg::DZ_W-1:0]          dz_r;
  logic [gam_pkg::GAIN_W-1:0]        gain_h_r, gain_v_r;
  logic [gam_pkg::BETA_W-1:0]        beta_r;
  logic                              en_r;
  logic                              busy_r;
  logic [gam_pkg::BTN_W-1:0]         btn_r;
  logic                              cfg_wr, accept, start, clear, retire;
  logic [gam_pkg::TIME_W-1:0]        time_clamped;
  gam_pkg::gam_lane_res_t            lane_x, lane_y;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_ready  = !busy_r;
  assign accept    = in_valid && in_ready;
  // with motion off the request is taken and dropped
  assign start     = accept && en_r;
  assign clear     = cfg_wr && (cfg_index == gam_pkg::REG_ENABLE);

  always_comb begin
    if (in_elapsed_us < gam_pkg::TIME_MIN) begin
      time_clamped = gam_pkg::TIME_MIN[gam_pkg::TIME_W-1:0];
    end else if (in_elapsed_us > gam_pkg::TIME_MAX) begin
      time_clamped = gam_pkg::TIME_MAX[gam_pkg::TIME_W-1:0];
    end else begin
      time_clamped = in_elapsed_us[gam_pkg::TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_x_r <= '0;
      bias_y_r <= '0;
      dz_r     <= gam_pkg::DEADZONE_RST;
      gain_h_r <= gam_pkg::GAIN_RST;
      gain_v_r <= gam_pkg::GAIN_RST;
      beta_r   <= gam_pkg::SMOOTHING_RST;
      en_r     <= 1'b1;
      busy_r   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          gam_pkg::REG_BIAS_X:     bias_x_r <= cfg_data;
          gam_pkg::REG_BIAS_Y:     bias_y_r <= cfg_data;
          gam_pkg::REG_DEADZONE:   dz_r     <= cfg_data[gam_pkg::DZ_W-1:0];
          gam_pkg::REG_GAIN_HORIZ: gain_h_r <= cfg_data[gam_pkg::GAIN_W-1:0];
          gam_pkg::REG_GAIN_VERT:  gain_v_r <= cfg_data[gam_pkg::GAIN_W-1:0];
          gam_pkg::REG_SMOOTHING:  beta_r   <= cfg_data[gam_pkg::BETA_W-1:0];
          gam_pkg::REG_ENABLE:     en_r     <= cfg_data[0];
          default: ;
        endcase
      end
      if (start) begin
        busy_r <= 1'b1;
      end else if (retire) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      btn_r <= in_buttons;
    end
  end

  // horizontal motion comes from sensor y, vertical from sensor x (negated)
  gam_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (start),
    .clear_i  (clear),
    .negate_i (1'b0),
    .rate_i   (in_rate_raw_y),
    .bias_i   (bias_x_r),
    .dz_i     (dz_r),
    .gain_i   (gain_h_r),
    .beta_i   (beta_r),
    .time_i   (time_clamped),
    .res_o    (lane_x)
  );

  gam_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (start),
    .clear_i  (clear),
    .negate_i (1'b1),
    .rate_i   (in_rate_raw_x),
    .bias_i   (bias_y_r),
    .dz_i     (dz_r),
    .gain_i   (gain_v_r),
    .beta_i   (beta_r),
    .time_i   (time_clamped),
    .res_o    (lane_y)
  );

  gam_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .lx_i             (lane_x),
    .ly_i             (lane_y),
    .btn_i            (btn_r),
    .retire_o         (retire),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_move_x       (out_move_x),
    .out_move_y       (out_move_y),
    .out_button_state (out_button_state)
  );

endmodule

// ===== tb/tb_gyro_air_mouse_motion_top.sv =====
// tb_gyro_air_mouse_motion_top: self-checking bench for the gyro air-mouse motion block,
// with a bit-exact pointer motion model in a small scoreboard class.
// Depends on gam_pkg and gyro_air_mouse_motion_top from rtl/.
module tb_gyro_air_mouse_motion_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gam_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint unsigned DEG_SCALE_DIV = 64'd256000000000;
  localparam longint BETA_UNITY = 65536;
  localparam longint STEP_LIMIT = 127;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int HOLD_OFF = 40;
  localparam int IDLE_LIMIT = 5000;
  localparam logic signed [RATE_W-1:0] RATE_TOP = {1'b0, {(RATE_W-1){1'b1}}};
  localparam logic signed [RATE_W-1:0] RATE_BOTTOM = {1'b1, {(RATE_W-1){1'b0}}};

  typedef struct {
    logic signed [MOVE_W-1:0] mx;
    logic signed [MOVE_W-1:0] my;
    logic [BTN_W-1:0]         btn;
  } move_report_t;

  class pointer_motion_model;
    longint bias_h, bias_v, dead_band, gain_h, gain_v, beta;
    bit enabled;
    longint filt_h, filt_v, resid_h, resid_v;
    move_report_t moves_due[$];
    int bad_reports;

    function new();
      bias_h = 0;
      bias_v = 0;
      dead_band = DEADZONE_RST;
      gain_h = GAIN_RST;
      gain_v = GAIN_RST;
      beta = SMOOTHING_RST;
      enabled = 1'b1;
      bad_reports = 0;
      clear_motion();
    endfunction

    function void clear_motion();
      filt_h = 0;
      filt_v = 0;
      resid_h = 0;
      resid_v = 0;
    endfunction

    function void write_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_BIAS_X:     bias_h = longint'($signed(data));
        REG_BIAS_Y:     bias_v = longint'($signed(data));
        REG_DEADZONE:   dead_band = longint'(data[DZ_W-1:0]);
        REG_GAIN_HORIZ: gain_h = longint'(data[GAIN_W-1:0]);
        REG_GAIN_VERT:  gain_v = longint'(data[GAIN_W-1:0]);
        REG_SMOOTHING:  beta = longint'(data[BETA_W-1:0]);
        REG_ENABLE: begin
          enabled = data[0];
          clear_motion();
        end
        default: ;
      endcase
    endfunction

    function longint dead_zone_cut(longint r);
      longint a;
      a = (r < 0) ? -r : r;
      return (a < dead_band) ? 0 : r;
    endfunction

    // rate in mdps times Q8.8 gain times us, as counts with FRAC fraction bits
    function longint rate_to_counts(longint r, longint unsigned gain, longint unsigned us);
      bit neg;
      longint unsigned mag, prod, whole, part;
      neg = (r < 0);
      mag = neg ? -r : r;
      prod = mag * gain * us;
      whole = prod / DEG_SCALE_DIV;
      part = prod % DEG_SCALE_DIV;
      whole = (whole << FRAC) + ((part << FRAC) / DEG_SCALE_DIV);
      return neg ? -longint'(whole) : longint'(whole);
    endfunction

    function longint low_pass(longint prev, longint d);
      return (beta * prev + (BETA_UNITY - beta) * d) / BETA_UNITY;
    endfunction

    function longint pay_out(input longint acc, input longint f, output longint acc_next);
      longint lim, r, step;
      lim = (longint'(1) <<< (23 + FRAC)) - 1;
      r = acc + f;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      step = r / (longint'(1) <<< FRAC);
      if (step > STEP_LIMIT) step = STEP_LIMIT;
      if (step < -STEP_LIMIT) step = -STEP_LIMIT;
      acc_next = r - step * (longint'(1) <<< FRAC);
      return step;
    endfunction

    function void note_sample(logic signed [RATE_W-1:0] rx, logic signed [RATE_W-1:0] ry,
                              logic [ELAPSED_W-1:0] us, logic [BTN_W-1:0] btn);
      longint t, h, v, mh, mv;
      move_report_t rep;
      if (!enabled) return;
      t = us;
      if (t < TIME_MIN) t = TIME_MIN;
      if (t > TIME_MAX) t = TIME_MAX;
      // axes swapped, vertical negated
      h = dead_zone_cut(longint'(ry) - bias_h);
      v = -dead_zone_cut(longint'(rx) - bias_v);
      filt_h = low_pass(filt_h, rate_to_counts(h, gain_h, t));
      filt_v = low_pass(filt_v, rate_to_counts(v, gain_v, t));
      mh = pay_out(resid_h, filt_h, resid_h);
      mv = pay_out(resid_v, filt_v, resid_v);
      if (mh != 0 || mv != 0) begin
        rep.mx = mh[MOVE_W-1:0];
        rep.my = mv[MOVE_W-1:0];
        rep.btn = btn;
        moves_due.push_back(rep);
      end
    endfunction

    function void check_report(logic signed [MOVE_W-1:0] mx, logic signed [MOVE_W-1:0] my,
                               logic [BTN_W-1:0] btn);
      move_report_t want;
      if (moves_due.size() == 0) begin
        bad_reports++;
        if (bad_reports <= 10)
          $display("unexpected move x=%0d y=%0d buttons=%0d", mx, my, btn);
        return;
      end
      want = moves_due.pop_front();
      if (want.mx !== mx || want.my !== my || want.btn !== btn) begin
        bad_reports++;
        if (bad_reports <= 10)
          $display("move mismatch: want x=%0d y=%0d buttons=%0d, got x=%0d y=%0d buttons=%0d",
                   want.mx, want.my, want.btn, mx, my, btn);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [RATE_W-1:0]   in_rate_raw_x = '0;
  logic signed [RATE_W-1:0]   in_rate_raw_y = '0;
  logic [ELAPSED_W-1:0]       in_elapsed_us = '0;
  logic [BTN_W-1:0]           in_buttons = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [MOVE_W-1:0]   out_move_x;
  logic signed [MOVE_W-1:0]   out_move_y;
  logic [BTN_W-1:0]           out_button_state;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [IDX_W-1:0]           cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;

  pointer_motion_model model = new();

  int burst_left = 0;
  int run_left = 0;
  int max_run = 40;
  int extreme_pct = 0;
  longint base_x, base_y;
  logic [ELAPSED_W-1:0] base_t;
  int ready_mode = 0;
  int ready_hold = 0;
  int ready_tick = 0;

  wire handshake = (in_valid && in_ready) || (out_valid && out_ready) ||
                   (cfg_valid && cfg_ready);

  gyro_air_mouse_motion_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rate_raw_x    (in_rate_raw_x),
    .in_rate_raw_y    (in_rate_raw_y),
    .in_elapsed_us    (in_elapsed_us),
    .in_buttons       (in_buttons),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_move_x       (out_move_x),
    .out_move_y       (out_move_y),
    .out_button_state (out_button_state),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      model.note_sample(in_rate_raw_x, in_rate_raw_y, in_elapsed_us, in_buttons);
    if (rst_n && out_valid && out_ready)
      model.check_report(out_move_x, out_move_y, out_button_state);
    if (rst_n && cfg_valid && cfg_ready)
      model.write_register(cfg_index, cfg_data);
  end

  // receiver stall pattern, with its style picked anew at random from four
  always @(posedge clk) begin
    ready_tick++;
    if (ready_tick % 600 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 6);
      2: out_ready <= ((ready_tick % 7) < 4);
      default: begin
        if (ready_hold == 0) begin
          out_ready <= ~out_ready;
          ready_hold = $urandom_range(1, 40);
        end else begin
          ready_hold--;
        end
      end
    endcase
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (handshake) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_sample(input logic signed [RATE_W-1:0] rx,
                             input logic signed [RATE_W-1:0] ry,
                             input logic [ELAPSED_W-1:0] us, input logic [BTN_W-1:0] btn);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_rate_raw_x <= rx;
    in_rate_raw_y <= ry;
    in_elapsed_us <= us;
    in_buttons <= btn;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender until every expected move is out, then let the pipe empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (model.moves_due.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic logic [CFG_W-1:0] near_bias();
    return $urandom_range(0, 100000) - 50000;
  endfunction

  task automatic apply_settings(input int kind);
    case (kind)
      0, 5: begin
        put_reg(REG_BIAS_X, near_bias());
        put_reg(REG_BIAS_Y, near_bias());
        put_reg(REG_DEADZONE, $urandom_range(0, 20000));
        put_reg(REG_GAIN_HORIZ, $urandom_range(256, 8000));
        put_reg(REG_GAIN_VERT, $urandom_range(256, 8000));
        put_reg(REG_SMOOTHING, $urandom_range(0, 65535));
        put_reg(REG_ENABLE, ($urandom << 1) | 1);
        max_run = 40;
        extreme_pct = 0;
      end
      1: begin
        // full gain, no filter, no deadzone: drives the residue into saturation
        put_reg(REG_BIAS_X, '0);
        put_reg(REG_BIAS_Y, '0);
        put_reg(REG_DEADZONE, '0);
        put_reg(REG_GAIN_HORIZ, 16'hFFFF);
        put_reg(REG_GAIN_VERT, 16'hFFFF);
        put_reg(REG_SMOOTHING, '0);
        max_run = 220;
        extreme_pct = 70;
      end
      2: begin
        put_reg(REG_BIAS_X, RATE_TOP);
        put_reg(REG_BIAS_Y, RATE_BOTTOM);
        put_reg(REG_DEADZONE, $urandom_range(0, 5000));
        put_reg(REG_GAIN_HORIZ, '0);
        put_reg(REG_GAIN_VERT, $urandom_range(1000, 65535));
        put_reg(REG_SMOOTHING, 16'hFFFF);
        max_run = 40;
        extreme_pct = 10;
      end
      3: begin
        put_reg(REG_DEADZONE, {CFG_W{1'b1}});
        put_reg(REG_GAIN_HORIZ, $urandom);
        put_reg(REG_GAIN_VERT, $urandom);
        put_reg(REG_SMOOTHING, $urandom);
        put_reg(REG_UNUSED, $urandom);
        max_run = 40;
        extreme_pct = 30;
      end
      4: begin
        put_reg(REG_BIAS_X, near_bias());
        put_reg(REG_DEADZONE, $urandom_range(0, 4000));
        put_reg(REG_ENABLE, $urandom << 1);
        extreme_pct = 0;
      end
      default: begin
        put_reg(REG_BIAS_X, ($urandom_range(0, 3) == 0) ? $urandom : near_bias());
        put_reg(REG_BIAS_Y, ($urandom_range(0, 3) == 0) ? $urandom : near_bias());
        put_reg(REG_DEADZONE, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 30000) : $urandom);
        put_reg(REG_GAIN_HORIZ, $urandom);
        put_reg(REG_GAIN_VERT, $urandom);
        put_reg(REG_SMOOTHING, $urandom);
        if ($urandom_range(0, 1) == 0) put_reg(REG_UNUSED, $urandom);
        put_reg(REG_ENABLE, $urandom | 1);
        max_run = 60;
        extreme_pct = 5;
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  function automatic longint pick_rate();
    logic [RATE_W-1:0] bits;
    longint mag;
    bits = $urandom;
    if ($urandom_range(0, 99) < extreme_pct)
      return bits[0] ? longint'(RATE_TOP) : longint'(RATE_BOTTOM);
    case ($urandom_range(0, 9))
      0: begin
        case (bits[1:0])
          2'd0: return longint'(RATE_TOP);
          2'd1: return longint'(RATE_BOTTOM);
          2'd2: return 0;
          default: return -1;
        endcase
      end
      1, 2: mag = $urandom_range(0, 6000);
      8, 9: return longint'($signed(bits));
      default: mag = $urandom_range(0, 400000);
    endcase
    return bits[2] ? -mag : mag;
  endfunction

  function automatic logic [ELAPSED_W-1:0] pick_time();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 999);
      1: return $urandom_range(50001, 1048575);
      2: return $urandom;
      3: begin
        case ($urandom_range(0, 3))
          0: return TIME_MIN;
          1: return TIME_MAX;
          2: return TIME_MIN - 1;
          default: return TIME_MAX + 1;
        endcase
      end
      default: return $urandom_range(1000, 50000);
    endcase
  endfunction

  // hand-motion runs: a steady rate with jitter, now and then a fully random sample
  task automatic pick_sample(output logic signed [RATE_W-1:0] rx,
                             output logic signed [RATE_W-1:0] ry,
                             output logic [ELAPSED_W-1:0] us, output logic [BTN_W-1:0] btn);
    longint jx, jy;
    if (run_left == 0) begin
      run_left = $urandom_range(1, max_run);
      base_x = pick_rate();
      base_y = pick_rate();
      base_t = pick_time();
    end
    run_left--;
    btn = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      rx = $urandom;
      ry = $urandom;
      us = $urandom;
    end else begin
      jx = longint'($urandom_range(0, 4000)) - 2000;
      jy = longint'($urandom_range(0, 4000)) - 2000;
      rx = base_x + jx;
      ry = base_y + jy;
      us = ($urandom_range(0, 7) == 0) ? pick_time() : base_t;
    end
  endtask

  task automatic run_directed();
    send_sample(0, 0, 10000, 2'd0);
    send_sample(0, 100000, 10000, 2'd1);
    send_sample(100000, 0, 10000, 2'd2);
    send_sample(1999, -1999, 10000, 2'd3);
    send_sample(2000, -2000, 10000, 2'd0);
    send_sample(RATE_TOP, RATE_TOP, 50000, 2'd3);
    send_sample(RATE_BOTTOM, RATE_BOTTOM, {ELAPSED_W{1'b1}}, 2'd1);
    send_sample(RATE_TOP, RATE_BOTTOM, 0, 2'd2);
    send_sample(-500000, 500000, TIME_MIN - 1, 2'd1);
    send_sample(-500000, 500000, TIME_MIN, 2'd2);
    send_sample(-500000, 500000, TIME_MAX, 2'd0);
    send_sample(-500000, 500000, TIME_MAX + 1, 2'd3);
    // slow drift: moves come only from the accumulated fraction
    for (int i = 0; i < 6; i++) send_sample(3000, -3000, TIME_MIN, i[1:0]);
    send_sample(-1, 0, TIME_MIN, 2'd0);
    send_sample(0, -1, TIME_MIN, 2'd0);
    send_sample(22'h2AAAAA, 22'h155555, 20'hAAAAA, 2'b01);
    send_sample(22'h155555, 22'h2AAAAA, 20'h55555, 2'b10);
  endtask

  initial begin
    int n;
    logic signed [RATE_W-1:0] rx, ry;
    logic [ELAPSED_W-1:0] us;
    logic [BTN_W-1:0] btn;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int ph = 0; ph < 9; ph++) begin
      wait_drained();
      apply_settings(ph);
      n = (ph == 4) ? 60 : (ph == 1) ? 320 : 220;
      for (int k = 0; k < n; k++) begin
        if (k == n / 2 && (ph == 0 || $urandom_range(0, 2) == 0)) wait_drained();
        pick_sample(rx, ry, us, btn);
        send_sample(rx, ry, us, btn);
      end
    end
    wait_drained();
    if (model.moves_due.size() != 0)
      $display("%0d expected moves never came out", model.moves_due.size());
    if (model.bad_reports == 0 && model.moves_due.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gam_pkg.sv
rtl/gam_div.sv
rtl/gam_lane.sv
rtl/gam_merge.sv
rtl/gyro_air_mouse_motion_top.sv
tb/tb_gyro_air_mouse_motion_top.sv
